>>> rtl/tlb_page_table_translator_core_assert.svh
// assertion macros for the translator
`ifndef TLB_PAGE_TABLE_TRANSLATOR_CORE_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_CORE_ASSERT_SVH
`define TPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`define TPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`endif

>>> rtl/tpt_pkg.sv
package tpt_pkg;
    typedef enum logic [1:0] {
        OUT_TLB_HIT   = 2'd0,
        OUT_PT_HIT    = 2'd1,
        OUT_FAULT     = 2'd2,
        OUT_UNUSED    = 2'd3
    } outcome_t;
    localparam logic [15:0] CNT_MAX = 16'hffff;
    // one entry per 8-bit page
    localparam int PAGE_TABLE_ENTRIES = 256;
endpackage

>>> rtl/tpt_tlb.sv
module tpt_tlb
    import tpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] lookup_page,
    output logic       hit,
    output logic [7:0] hit_frame,
    input  logic       fill_en,
    input  logic [7:0] fill_page,
    input  logic [7:0] fill_frame,
    input  logic       drop_en,
    input  logic [7:0] drop_page
);
    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    logic [7:0] tag_reg [TLB_ENTRIES];
    logic [7:0] frm_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [IW-1:0] ptr_reg;

    // parallel compare, lowest index wins
    always_comb
    begin
        hit = 1'b0;
        hit_frame = 8'd0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == lookup_page)
            begin
                hit = 1'b1;
                hit_frame = frm_reg[i];
            end
        end
    end

    // drop then round-robin fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < TLB_ENTRIES; i++)
                if (drop_en && valid_reg[i] && tag_reg[i] == drop_page)
                    valid_reg[i] <= 1'b0;
            if (fill_en)
            begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg <= (ptr_reg == IW'(TLB_ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_en)
        begin
            tag_reg[ptr_reg] <= fill_page;
            frm_reg[ptr_reg] <= fill_frame;
        end
    end
endmodule

>>> rtl/tlb_page_table_translator_core.sv
// address translator with tlb and demand-paged page table
// input channel: in_valid/in_stall with logical_address (page 15:8, offset 7:0)
// output channel: out_valid/out_stall carrying one result word per input word
// config: cfg_we/cfg_wdata writes frames_available; the user writes it only while
// idle, which the core does not enforce; a word's page-table and owner entries
// are read from synchronous memories in the accept cycle; the next cycle looks
// it up in the tlb, resolves hit, page-table hit or fault, writes the memories
// back on a fault and loads the output register. accept sets busy_reg, which
// sets out_valid; no new word is taken while busy_reg is set (the page table and
// owner memories are read then written back) or while a result is held back by
// out_stall; a stalled result holds its value and blocks the input
// reset clears tlb valid bits, page present bits, the frame pointer, the
// counters and the output valid; the page-frame and owner memories are left
// undefined and are only trusted behind a present bit
module tlb_page_table_translator_core
    import tpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int MAX_FRAMES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] logical_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] physical_address,
    output logic [7:0]  frame_number,
    output logic [1:0]  outcome,
    output logic [7:0]  fill_page,
    output logic        evicted_valid,
    output logic [7:0]  evicted_page,
    output logic [15:0] fault_total,
    output logic [15:0] tlb_hit_total,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);
    localparam int PW = (PAGE_TABLE_ENTRIES > 1) ? $clog2(PAGE_TABLE_ENTRIES) : 1;
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [8:0] frames_reg;
    logic       busy_reg;
    logic [7:0] page_reg, off_reg;
    logic [PAGE_TABLE_ENTRIES-1:0] present_reg;
    logic [7:0] page_frame_mem [PAGE_TABLE_ENTRIES];
    logic [7:0] frame_owner_mem [MAX_FRAMES];
    logic [7:0] pf_rd_reg, own_rd_reg;
    logic [7:0] next_frame_reg;
    logic       full_reg;
    logic [15:0] fault_reg, hit_reg;
    logic       accept;
    logic [7:0] in_page, sel_frame_in;
    logic [8:0] lim;
    logic       tlb_hit;
    logic [7:0] tlb_frame;
    logic       is_tlb, is_pt, is_fault;
    logic [7:0] fault_frame, old_page, res_frame;
    logic       evict;
    logic [8:0] nf_inc;

    // frame limit clamp
    always_comb
    begin
        lim = frames_reg;
        if (lim == 9'd0) lim = 9'd1;
        if (lim > 9'(MAX_FRAMES)) lim = 9'(MAX_FRAMES);
    end

    assign in_stall = busy_reg || (out_valid && out_stall);
    assign accept = in_valid && !in_stall;
    assign in_page = 8'(logical_address[15:8] % PAGE_TABLE_ENTRIES);
    // frame this fault would take, needed for owner read in accept cycle
    assign sel_frame_in = ({1'b0, next_frame_reg} >= lim) ? 8'd0 : next_frame_reg;

    tpt_tlb #(.TLB_ENTRIES(TLB_ENTRIES)) u_tlb (
        .clk(clk), .rst_n(rst_n),
        .lookup_page(page_reg), .hit(tlb_hit), .hit_frame(tlb_frame),
        .fill_en(busy_reg && !tlb_hit && (is_pt || is_fault)),
        .fill_page(page_reg), .fill_frame(res_frame),
        .drop_en(busy_reg && evict), .drop_page(old_page)
    );

    // resolve stage
    // a recorded owner that is still present always maps to its frame, since a
    // page only leaves its frame when that frame is taken again here
    always_comb
    begin
        is_tlb = tlb_hit;
        is_pt = !tlb_hit && present_reg[page_reg[PW-1:0]];
        is_fault = !tlb_hit && !is_pt;
        fault_frame = sel_frame_in;
        old_page = 8'(own_rd_reg % PAGE_TABLE_ENTRIES);
        evict = is_fault && full_reg && present_reg[old_page[PW-1:0]]
                && old_page != page_reg;
        if (is_tlb) res_frame = tlb_frame;
        else if (is_pt) res_frame = pf_rd_reg;
        else res_frame = fault_frame;
        nf_inc = {1'b0, fault_frame} + 9'd1;
    end

    // memory reads in the accept cycle, write-back of a fault in the resolve cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= in_page;
            off_reg <= logical_address[7:0];
            pf_rd_reg <= page_frame_mem[in_page[PW-1:0]];
            own_rd_reg <= frame_owner_mem[sel_frame_in[FW-1:0]];
        end
        if (busy_reg && is_fault)
        begin
            page_frame_mem[page_reg[PW-1:0]] <= fault_frame;
            frame_owner_mem[fault_frame[FW-1:0]] <= page_reg;
        end
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= 9'd256;
            busy_reg <= 1'b0;
            present_reg <= '0;
            next_frame_reg <= 8'd0;
            full_reg <= 1'b0;
            fault_reg <= 16'd0;
            hit_reg <= 16'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we) frames_reg <= cfg_wdata;
            if (out_valid && !out_stall) out_valid <= 1'b0;
            busy_reg <= accept;
            if (busy_reg)
            begin
                out_valid <= 1'b1;
                physical_address <= {res_frame, off_reg};
                frame_number <= res_frame;
                outcome <= is_tlb ? OUT_TLB_HIT : (is_pt ? OUT_PT_HIT : OUT_FAULT);
                fill_page <= is_fault ? page_reg : 8'd0;
                evicted_valid <= evict;
                evicted_page <= evict ? old_page : 8'd0;
                if (is_tlb && hit_reg != CNT_MAX) hit_reg <= hit_reg + 16'd1;
                tlb_hit_total <= (is_tlb && hit_reg != CNT_MAX) ? hit_reg + 16'd1 : hit_reg;
                fault_total <= (is_fault && fault_reg != CNT_MAX) ? fault_reg + 16'd1
                                                                   : fault_reg;
                if (is_fault)
                begin
                    if (fault_reg != CNT_MAX) fault_reg <= fault_reg + 16'd1;
                    if (evict) present_reg[old_page[PW-1:0]] <= 1'b0;
                    present_reg[page_reg[PW-1:0]] <= 1'b1;
                    if (nf_inc >= lim)
                    begin
                        next_frame_reg <= 8'd0;
                        full_reg <= 1'b1;
                    end
                    else
                        next_frame_reg <= nf_inc[7:0];
                end
            end
        end
    end
endmodule

>>> rtl/tpt_checker.sv
`include "tlb_page_table_translator_core_assert.svh"
module tpt_checker
    import tpt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] outcome,
    input logic [7:0] fill_page,
    input logic       evicted_valid
);
    `TPT_ASSERT_NEXT(a_accept_blocks, clk, rst_n, in_valid && !in_stall, in_stall)
    `TPT_ASSERT_IMP(a_code_ok, clk, rst_n, out_valid, outcome != OUT_UNUSED)
    `TPT_ASSERT_IMP(a_evict_fault, clk, rst_n, out_valid && evicted_valid, outcome == OUT_FAULT)
    `TPT_ASSERT_IMP(a_fill_zero, clk, rst_n, out_valid && outcome != OUT_FAULT, fill_page == 8'd0)
    `TPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(outcome))
endmodule

bind tlb_page_table_translator_core tpt_checker u_tpt_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .outcome(outcome),
    .fill_page(fill_page), .evicted_valid(evicted_valid)
);
